[design/assert_macros.svh]
// Assertion macros used by the message hasher.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, pre, post)
`define ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif
`endif

[design/sha256_pkg.sv]
// Package with payload types, state codes and SHA-256 constants.
package sha256_pkg;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       has_byte;
        logic       is_final;
    } in_word_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } out_word_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_LOAD,
        ST_RUN,
        ST_FOLD,
        ST_OUT
    } state_t;

    // Control from the sequencer to the round unit.
    typedef struct packed {
        logic       load;
        logic       step;
        logic       fold;
        logic       clear;
        logic [5:0] round;
    } round_ctl_t;

    localparam logic [31:0] IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] KROM [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] ror(input logic [31:0] v, input int n);
        ror = (v >> n) | (v << (32 - n));
    endfunction

endpackage

[design/sha256_round.sv]
// Shared round unit: message schedule window, working variables and chaining value.
module sha256_round (
    input  logic                   clk,
    input  logic                   rst_n,
    input  sha256_pkg::round_ctl_t ctl,
    input  logic [511:0]           block,
    output logic [255:0]           hash
);
    import sha256_pkg::*;

    logic [31:0] w_reg [16];
    logic [31:0] w_next [16];
    logic [31:0] v_reg [8];
    logic [31:0] v_next [8];
    logic [31:0] h_reg [8];
    logic [31:0] h_next [8];
    logic [31:0] s0, s1, wn, big0, big1, ch, maj, p, q;

    // Load, or one round with the schedule word for round+16; also fold and clear.
    always_comb
    begin
        s0   = ror(w_reg[1], 7) ^ ror(w_reg[1], 18) ^ (w_reg[1] >> 3);
        s1   = ror(w_reg[14], 17) ^ ror(w_reg[14], 19) ^ (w_reg[14] >> 10);
        wn   = s1 + w_reg[9] + s0 + w_reg[0];
        big1 = ror(v_reg[4], 6) ^ ror(v_reg[4], 11) ^ ror(v_reg[4], 25);
        ch   = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
        big0 = ror(v_reg[0], 2) ^ ror(v_reg[0], 13) ^ ror(v_reg[0], 22);
        maj  = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        p    = v_reg[7] + big1 + ch + KROM[ctl.round] + w_reg[0];
        q    = big0 + maj;
        w_next = w_reg;
        v_next = v_reg;
        h_next = h_reg;
        if (ctl.load)
        begin
            for (int i = 0; i < 16; i++)
                w_next[i] = block[511 - 32*i -: 32];
            v_next = h_reg;
        end
        else if (ctl.step)
        begin
            for (int i = 0; i < 15; i++)
                w_next[i] = w_reg[i+1];
            w_next[15] = wn;
            v_next[7] = v_reg[6];
            v_next[6] = v_reg[5];
            v_next[5] = v_reg[4];
            v_next[4] = v_reg[3] + p;
            v_next[3] = v_reg[2];
            v_next[2] = v_reg[1];
            v_next[1] = v_reg[0];
            v_next[0] = p + q;
        end
        if (ctl.fold)
            for (int i = 0; i < 8; i++)
                h_next[i] = h_reg[i] + v_reg[i];
        if (ctl.clear)
            h_next = IV;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            h_reg <= IV;
        else
            h_reg <= h_next;
    end

    always_ff @(posedge clk)
    begin
        w_reg <= w_next;
        v_reg <= v_next;
    end

    always_comb
    begin
        for (int i = 0; i < 8; i++)
            hash[255 - 32*i -: 32] = h_reg[i];
    end
endmodule

[design/sha256_message_hasher.sv]
// Top level: byte packing, padding sequencer and digest output.
//
//  channel | dir | payload    | handshake
//  in_*    | in  | in_word_t  | in_valid / in_ready
//  out_*   | out | out_word_t | out_valid / out_ready
//
// The word that fills a block is followed by load, 64 rounds and fold in the
// shared round unit. A final word adds one or two tail blocks, each preceded
// by a padding step, and then eight output words, each held until taken.
// Reset clears the chaining value to the initial hash and the counters to zero.
`include "assert_macros.svh"
module sha256_message_hasher (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  sha256_pkg::in_word_t  in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output sha256_pkg::out_word_t out_data
);
    import sha256_pkg::*;

    state_t      state_reg, state_next;
    logic [31:0] buf_reg [16];
    logic [31:0] buf_next [16];
    logic [63:0] cnt_reg, cnt_next;
    logic [5:0]  pos_reg, pos_next;
    logic [5:0]  rnd_reg, rnd_next;
    logic        fin_reg, fin_next;   // padding pending after this block
    logic        two_reg, two_next;   // length still needs its own block
    logic [2:0]  oidx_reg, oidx_next;
    logic [511:0] block;
    logic [255:0] hash;
    round_ctl_t  ctl;
    logic        acc;
    logic        last_acc;

    assign acc = in_valid && in_ready;
    assign last_acc = out_valid && out_ready && out_data.last_word;

    always_comb
    begin
        for (int i = 0; i < 16; i++)
            block[511 - 32*i -: 32] = buf_reg[i];
    end

    sha256_round u_round (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .block (block),
        .hash  (hash)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (acc)
                begin
                    if (in_data.has_byte && pos_reg == 6'd63)
                        state_next = ST_LOAD;
                    else if (in_data.is_final)
                        state_next = ST_PAD;
                end
            ST_PAD:  state_next = ST_LOAD;
            ST_LOAD: state_next = ST_RUN;
            ST_RUN:  if (rnd_reg == 6'd63) state_next = ST_FOLD;
            ST_FOLD:
                if (fin_reg || two_reg)
                    state_next = ST_PAD;
                else if (cnt_reg[0])
                    state_next = ST_OUT;
                else
                    state_next = ST_IDLE;
            ST_OUT:  if (out_ready && oidx_reg == 3'd7) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath and outputs. cnt_reg[0] flags that the digest is due.
    always_comb
    begin
        buf_next  = buf_reg;
        cnt_next  = cnt_reg;
        pos_next  = pos_reg;
        rnd_next  = rnd_reg;
        fin_next  = fin_reg;
        two_next  = two_reg;
        oidx_next = oidx_reg;
        ctl       = '0;
        ctl.round = rnd_reg;
        in_ready  = (state_reg == ST_IDLE);
        out_valid = (state_reg == ST_OUT);
        out_data.digest_word = hash[255 - 32*oidx_reg -: 32];
        out_data.word_index  = oidx_reg;
        out_data.last_word   = (oidx_reg == 3'd7);
        case (state_reg)
            ST_IDLE:
                if (acc)
                begin
                    if (in_data.has_byte)
                    begin
                        buf_next[pos_reg[5:2]][31 - 8*pos_reg[1:0] -: 8] = in_data.byte_value;
                        cnt_next = cnt_reg + 64'd8;
                        pos_next = pos_reg + 6'd1;
                    end
                    fin_next = in_data.is_final;
                    rnd_next = '0;
                end
            ST_PAD:
            begin
                // Marker unless two_reg, zero fill, length if room remains.
                for (int w = 0; w < 16; w++)
                begin
                    for (int l = 0; l < 4; l++)
                    begin
                        if (6'(4*w + l) == pos_reg && !two_reg)
                            buf_next[w][31 - 8*l -: 8] = 8'h80;
                        else if (6'(4*w + l) > pos_reg || two_reg)
                            buf_next[w][31 - 8*l -: 8] = 8'h00;
                    end
                end
                if (pos_reg < 6'd56 || two_reg)
                begin
                    buf_next[14] = cnt_reg[63:32];
                    buf_next[15] = cnt_reg[31:0];
                    two_next = 1'b0;
                    fin_next = 1'b0;
                    cnt_next[0] = 1'b1;
                end
                else
                begin
                    two_next = 1'b1;
                    fin_next = 1'b0;
                end
            end
            ST_LOAD:
            begin
                // The block register now holds the complete block.
                ctl.load = 1'b1;
                rnd_next = '0;
            end
            ST_RUN:
            begin
                ctl.step = 1'b1;
                rnd_next = rnd_reg + 6'd1;
            end
            ST_FOLD:
            begin
                ctl.fold = 1'b1;
                rnd_next = '0;
            end
            ST_OUT:
                if (out_ready)
                begin
                    oidx_next = oidx_reg + 3'd1;
                    if (oidx_reg == 3'd7)
                    begin
                        ctl.clear = 1'b1;
                        cnt_next = '0;
                        pos_next = '0;
                    end
                end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            pos_reg   <= '0;
            rnd_reg   <= '0;
            fin_reg   <= 1'b0;
            two_reg   <= 1'b0;
            oidx_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            pos_reg   <= pos_next;
            rnd_reg   <= rnd_next;
            fin_reg   <= fin_next;
            two_reg   <= two_next;
            oidx_reg  <= oidx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        buf_reg <= buf_next;
    end

    `ASSERT_IMPLIES(a_no_out_when_busy, clk, rst_n, out_valid, !in_ready)
    `ASSERT_NEXT(a_clear_after_last, clk, rst_n, last_acc, pos_reg == 6'd0 && cnt_reg == 64'd0)
    `ASSERT_IMPLIES(a_run_counts, clk, rst_n, state_reg == ST_FOLD, rnd_reg == 6'd0)
endmodule

[tb/sv/sha256_message_hasher_tb.sv]
// Self-checking testbench for the SHA-256 message hasher.
`timescale 1ns / 1ps

module sha256_message_hasher_tb;
    import sha256_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int MAX_REPORTS = 10;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_word_t  in_data;
    logic      out_valid;
    logic      out_ready;
    out_word_t out_data;

    // Idling percentages for each side and a receiver hold-off, changed between phases.
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    int unsigned hold_off_cycles;

    // Predictor state: chaining value, block words, length and fill position.
    logic [31:0] chain_words [8];
    logic [31:0] block_words [16];
    logic [63:0] msg_length_bits;
    logic [5:0]  fill_slot;

    out_word_t   expected_digest_q [$];
    int unsigned mismatch_count;
    int unsigned idle_cycles;

    sha256_message_hasher dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // Clock generation, 10 ns period.
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [31:0] rotr(input logic [31:0] v, input int n);
        return (v >> n) | (v << (32 - n));
    endfunction

    // Start a fresh message in the predictor.
    task automatic clear_message();
        for (int i = 0; i < 8; i++)
        begin
            chain_words[i] = IV[i];
        end
        for (int i = 0; i < 16; i++)
        begin
            block_words[i] = '0;
        end
        msg_length_bits = '0;
        fill_slot = '0;
    endtask

    task automatic place_byte(input int slot, input logic [7:0] b);
        int w;
        int sh;
        w = slot / 4;
        sh = (3 - (slot % 4)) * 8;
        if (slot % 4 == 0)
        begin
            block_words[w] = 32'(b) << sh;
        end
        else
        begin
            block_words[w] |= 32'(b) << sh;
        end
    endtask

    // One SHA-256 compression of the current block into the chaining value.
    task automatic compress_block();
        logic [31:0] sched [64];
        logic [31:0] v [8];
        logic [31:0] s0, s1, p, q;
        for (int t = 0; t < 16; t++)
        begin
            sched[t] = block_words[t];
        end
        for (int t = 16; t < 64; t++)
        begin
            s0 = rotr(sched[t-15], 7) ^ rotr(sched[t-15], 18) ^ (sched[t-15] >> 3);
            s1 = rotr(sched[t-2], 17) ^ rotr(sched[t-2], 19) ^ (sched[t-2] >> 10);
            sched[t] = s1 + sched[t-7] + s0 + sched[t-16];
        end
        for (int t = 0; t < 8; t++)
        begin
            v[t] = chain_words[t];
        end
        for (int t = 0; t < 64; t++)
        begin
            p = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
                + ((v[4] & v[5]) ^ (~v[4] & v[6])) + KROM[t] + sched[t];
            q = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
                + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4];
            v[4] = v[3] + p;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0];
            v[0] = p + q;
        end
        for (int t = 0; t < 8; t++)
        begin
            chain_words[t] += v[t];
        end
    endtask

    // Predict the effect of one accepted word, queueing any digest words.
    task automatic predict_hash(input in_word_t w);
        out_word_t r;
        if (w.has_byte)
        begin
            place_byte(fill_slot, w.byte_value);
            msg_length_bits += 64'd8;
            fill_slot += 6'd1;
            if (fill_slot == 0)
            begin
                compress_block();
            end
        end
        if (w.is_final)
        begin
            place_byte(fill_slot, 8'h80);
            for (int s = fill_slot + 1; s < 64; s++)
            begin
                place_byte(s, 8'h00);
            end
            // Long tail: the length needs a block of its own.
            if (fill_slot >= 56)
            begin
                compress_block();
                for (int i = 0; i < 16; i++)
                begin
                    block_words[i] = '0;
                end
            end
            block_words[14] = msg_length_bits[63:32];
            block_words[15] = msg_length_bits[31:0];
            compress_block();
            for (int k = 0; k < 8; k++)
            begin
                r.digest_word = chain_words[k];
                r.word_index = 3'(k);
                r.last_word = (k == 7);
                expected_digest_q = {expected_digest_q, r};
            end
            clear_message();
        end
    endtask

    // Offer one word and hold it until accepted; valid drops only for idling.
    task automatic send_word(input logic [7:0] b, input bit has, input bit fin);
        in_word_t w;
        w.byte_value = b;
        w.has_byte = has;
        w.is_final = fin;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= w;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        predict_hash(w);
    endtask

    // A whole message of random bytes, with occasional empty words mixed in.
    task automatic send_message(input int len, input bit final_has_byte);
        int sent;
        sent = 0;
        while (sent < len)
        begin
            if ($urandom_range(19) == 0)
            begin
                send_word(8'($urandom), 1'b0, 1'b0);
            end
            else
            begin
                send_word(8'($urandom), 1'b1, 1'b0);
                sent++;
            end
        end
        send_word(8'($urandom), final_has_byte, 1'b1);
    endtask

    // The sender goes quiet until every expected digest word has arrived.
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_digest_q.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Directed: empty message, extreme bytes, and padding boundary lengths.
    task automatic test_directed();
        send_word(8'hff, 1'b0, 1'b1);
        send_word(8'h00, 1'b1, 1'b1);
        send_word(8'hff, 1'b1, 1'b0);
        send_word(8'h5a, 1'b0, 1'b0);
        send_word(8'hff, 1'b1, 1'b1);
        send_message(55, 1'b0);
        send_message(55, 1'b1);
        send_message(56, 1'b0);
        send_message(63, 1'b1);
        send_message(64, 1'b0);
    endtask

    // Random messages, mostly short, under one idling setting.
    task automatic test_random(input int n_items, input int unsigned idle_pct,
                               input int unsigned stall_pct);
        int budget;
        int len;
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        budget = n_items;
        while (budget > 0)
        begin
            len = ($urandom_range(9) == 0) ? $urandom_range(130) : $urandom_range(20);
            send_message(len, 1'($urandom));
            budget -= len + 1;
        end
        wait_drained();
    endtask

    // Receiver holds off for a long stretch while the sender keeps offering words.
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off_cycles = 600;
        send_message(3, 1'b1);
        send_message(70, 1'b0);
        send_message(2, 1'b1);
        wait_drained();
    endtask

    // Receiver side: random stalls plus an optional long hold-off.
    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off_cycles > 0)
            begin
                out_ready <= 1'b0;
                hold_off_cycles--;
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Compare each accepted digest word with the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_digest_q.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                begin
                    $display("Unexpected digest word %h idx %0d last %0b",
                             out_data.digest_word, out_data.word_index, out_data.last_word);
                end
            end
            else
            begin
                automatic out_word_t e = expected_digest_q.pop_front();
                if (out_data.digest_word !== e.digest_word
                    || out_data.word_index !== e.word_index
                    || out_data.last_word !== e.last_word)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                    begin
                        $display("Mismatch: expected %h/%0d/%0b, got %h/%0d/%0b",
                                 e.digest_word, e.word_index, e.last_word,
                                 out_data.digest_word, out_data.word_index,
                                 out_data.last_word);
                    end
                end
            end
        end
    end

    // Watchdog on cycles with no accepted word on either side.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles == WATCHDOG_LIMIT)
            begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off_cycles = 0;
        mismatch_count = 0;
        idle_cycles = 0;
        clear_message();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        wait_drained();
        test_backpressure();
        test_random(30, 0, 0);
        test_random(30, 50, 0);
        test_random(30, 0, 50);
        test_random(30, 22, 22);

        wait_drained();
        repeat (200) @(posedge clk);
        if (mismatch_count == 0 && expected_digest_q.size() == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
